@@ sv/turn_rate_limited_pursuit_steering_assert.svh @@
// Assertion macros for the pursuit steering block
`ifndef TURN_RATE_LIMITED_PURSUIT_STEERING_ASSERT_SVH
`define TURN_RATE_LIMITED_PURSUIT_STEERING_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TRPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define TRPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/trps_pkg.sv @@
// Shared types, widths and constants of the pursuit steering block
`timescale 1ns / 1ps
package trps_pkg;

    localparam int TIME_W   = 32;
    localparam int STEP_W   = 16;
    localparam int RANGE_W  = 24;
    localparam int FOV_W    = 16;
    localparam int RATE_W   = 20;
    localparam int SPEED_W  = 16;
    localparam int IDENT_W  = 16;
    localparam int VEL_W    = 17;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FLIGHT_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_RANGE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_OF_VIEW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_RATE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_TRACK  = 3'd7;

    localparam logic [STATUS_W-1:0] ST_INACTIVE = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXPIRED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELAY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PERIOD   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_TRACK = 3'd4;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_VIEW     = 3'd6;
    localparam logic [STATUS_W-1:0] ST_STEERED  = 3'd7;

    // turn limit: rate * step, then divide by 1000
    localparam int PROD_W    = RATE_W + STEP_W;
    localparam int MUL_DIGIT = 4;
    localparam int DIV_DIGIT = 3;
    localparam int DIV_REM_W = 10;
    localparam logic [DIV_REM_W:0] TURN_DIVISOR = 11'd1000;

    // sine/cosine: turn angle of 32 bits, Q30 internal values
    localparam int TURN_W       = 32;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_FRAC  = 30;
    localparam int CORDIC_STEPS = 24;
    localparam int ITER_W       = 5;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

    localparam int VMUL_DIGIT = 4;

    typedef struct packed {
        logic [TIME_W-1:0]  flight_limit_ms;
        logic [TIME_W-1:0]  start_delay_ms;
        logic [TIME_W-1:0]  update_period_ms;
        logic [RANGE_W-1:0] lock_range;
        logic [FOV_W-1:0]   field_of_view;
        logic [RATE_W-1:0]  turn_rate;
        logic [SPEED_W-1:0] cruise_speed;
        logic [IDENT_W-1:0] wanted_track;
    } trps_cfg_t;

    // arctangent of 2^-i in units of 2^32 per turn
    function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [ITER_W-1:0] i);
        case (i)
            5'd0:    return 34'sd536870912;
            5'd1:    return 34'sd316933406;
            5'd2:    return 34'sd167458907;
            5'd3:    return 34'sd85004756;
            5'd4:    return 34'sd42667331;
            5'd5:    return 34'sd21354465;
            5'd6:    return 34'sd10679838;
            5'd7:    return 34'sd5340245;
            5'd8:    return 34'sd2670163;
            5'd9:    return 34'sd1335087;
            5'd10:   return 34'sd667544;
            5'd11:   return 34'sd333772;
            5'd12:   return 34'sd166886;
            5'd13:   return 34'sd83443;
            5'd14:   return 34'sd41722;
            5'd15:   return 34'sd20861;
            5'd16:   return 34'sd10430;
            5'd17:   return 34'sd5215;
            5'd18:   return 34'sd2608;
            5'd19:   return 34'sd1304;
            5'd20:   return 34'sd652;
            5'd21:   return 34'sd326;
            5'd22:   return 34'sd163;
            5'd23:   return 34'sd81;
            default: return '0;
        endcase
    endfunction

endpackage

@@ sv/trps_cfg_regs.sv @@
// Configuration register file of the pursuit steering block
`timescale 1ns / 1ps
module trps_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [trps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trps_pkg::CFG_DATA_W-1:0] cfg_data,
    output trps_pkg::trps_cfg_t            cfg
);
    import trps_pkg::*;

    trps_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FLIGHT_LIMIT:  cfg_reg.flight_limit_ms  <= cfg_data;
                CFG_START_DELAY:   cfg_reg.start_delay_ms   <= cfg_data;
                CFG_UPDATE_PERIOD: cfg_reg.update_period_ms <= cfg_data;
                CFG_LOCK_RANGE:    cfg_reg.lock_range       <= cfg_data[RANGE_W-1:0];
                CFG_FIELD_OF_VIEW: cfg_reg.field_of_view    <= cfg_data[FOV_W-1:0];
                CFG_TURN_RATE:     cfg_reg.turn_rate        <= cfg_data[RATE_W-1:0];
                CFG_CRUISE_SPEED:  cfg_reg.cruise_speed     <= cfg_data[SPEED_W-1:0];
                CFG_WANTED_TRACK:  cfg_reg.wanted_track     <= cfg_data[IDENT_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

@@ sv/trps_limit.sv @@
// Digit-serial turn limit: turn_rate * step_ms / 1000, rounded down
`timescale 1ns / 1ps
module trps_limit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [trps_pkg::RATE_W-1:0] turn_rate,
    input  logic [trps_pkg::STEP_W-1:0] step_ms,
    output logic                        done,
    output logic [trps_pkg::PROD_W-1:0] lim
);
    import trps_pkg::*;

    localparam int MUL_STEPS = STEP_W / MUL_DIGIT;
    localparam int DIV_STEPS = PROD_W / DIV_DIGIT;
    localparam int MAX_STEPS = (MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS;
    localparam int CNT_W     = $clog2(MAX_STEPS);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]           phase_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 done_reg;
    logic [RATE_W-1:0]    rate_reg;
    logic [STEP_W-1:0]    step_sh_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [DIV_REM_W-1:0] rem_reg;

    logic [MUL_DIGIT-1:0]        digit;
    logic [RATE_W+MUL_DIGIT-1:0] part;
    logic [PROD_W-1:0]           acc_mul_next;
    logic [PROD_W-1:0]           acc_div_next;
    logic [DIV_REM_W-1:0]        rem_next;
    logic [DIV_REM_W:0]          trial;
    logic                        last_mul;
    logic                        last_div;

    assign digit        = step_sh_reg[STEP_W-1 -: MUL_DIGIT];
    assign part         = rate_reg * digit;
    assign acc_mul_next = {acc_reg[PROD_W-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}} + PROD_W'(part);
    assign last_mul     = (cnt_reg == CNT_W'(MUL_STEPS - 1));
    assign last_div     = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    // restoring division, quotient bits shift in where numerator bits leave
    always_comb
    begin
        acc_div_next = acc_reg;
        rem_next     = rem_reg;
        trial        = '0;
        for (int k = 0; k < DIV_DIGIT; k++)
        begin
            trial        = {rem_next, acc_div_next[PROD_W-1]};
            acc_div_next = {acc_div_next[PROD_W-2:0], 1'b0};
            if (trial >= TURN_DIVISOR)
            begin
                trial           = trial - TURN_DIVISOR;
                acc_div_next[0] = 1'b1;
            end
            rem_next = trial[DIV_REM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (phase_reg == PH_DIV) && last_div;
            case (phase_reg)
                PH_IDLE:
                begin
                    cnt_reg <= '0;
                    if (start)
                    begin
                        phase_reg <= PH_MUL;
                    end
                end
                PH_MUL:
                begin
                    if (last_mul)
                    begin
                        cnt_reg   <= '0;
                        phase_reg <= PH_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                PH_DIV:
                begin
                    if (last_div)
                    begin
                        cnt_reg   <= '0;
                        phase_reg <= PH_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    rate_reg    <= turn_rate;
                    step_sh_reg <= step_ms;
                    acc_reg     <= '0;
                    rem_reg     <= '0;
                end
            end
            PH_MUL:
            begin
                acc_reg     <= acc_mul_next;
                step_sh_reg <= {step_sh_reg[STEP_W-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}};
            end
            PH_DIV:
            begin
                acc_reg <= acc_div_next;
                rem_reg <= rem_next;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign lim  = acc_reg;

endmodule

@@ sv/trps_cordic.sv @@
// Iterative CORDIC sine and cosine of a turn angle, rounded to Q1.F
`timescale 1ns / 1ps
module trps_cordic #(
    parameter int SINE_FRAC_BITS = 15
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [trps_pkg::TURN_W-1:0]         angle,
    output logic                               done,
    output logic signed [SINE_FRAC_BITS:0]     sine,
    output logic signed [SINE_FRAC_BITS:0]     cosine
);
    import trps_pkg::*;

    localparam int SQ_W = SINE_FRAC_BITS + 1;
    localparam int SH   = CORDIC_FRAC - SINE_FRAC_BITS;
    localparam logic signed [CORDIC_W-1:0] Q_ROUND = CORDIC_W'(64'sd1 <<< (SH - 1));
    localparam logic signed [CORDIC_W-1:0] Q_MAX   =
        CORDIC_W'((64'sd1 <<< SINE_FRAC_BITS) - 64'sd1);
    localparam logic signed [CORDIC_W-1:0] Q_MIN   = CORDIC_W'(-(64'sd1 <<< SINE_FRAC_BITS));
    localparam logic [TURN_W-1:0] EIGHTH = TURN_W'(64'd1 << (TURN_W - 3));

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ITER = 2'd1;
    localparam logic [1:0] PH_MAP  = 2'd2;

    function automatic logic signed [SQ_W-1:0] to_q(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W-1:0] r;
        r = (v + Q_ROUND) >>> SH;
        if (r > Q_MAX)
        begin
            r = Q_MAX;
        end
        else if (r < Q_MIN)
        begin
            r = Q_MIN;
        end
        return r[SQ_W-1:0];
    endfunction

    logic [1:0]                 phase_reg;
    logic [ITER_W-1:0]          iter_reg;
    logic                       done_reg;
    logic [1:0]                 quad_reg;
    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [CORDIC_W-1:0] z_reg;
    logic signed [SQ_W-1:0]     sine_reg;
    logic signed [SQ_W-1:0]     cosine_reg;

    logic [TURN_W-1:0]          angle_bias;
    logic [1:0]                 quad_next;
    logic [TURN_W-1:0]          resid;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [CORDIC_W-1:0] at;
    logic signed [CORDIC_W-1:0] x_next;
    logic signed [CORDIC_W-1:0] y_next;
    logic signed [CORDIC_W-1:0] z_next;
    logic signed [CORDIC_W-1:0] s_pre;
    logic signed [CORDIC_W-1:0] c_pre;

    assign angle_bias = angle + EIGHTH;
    assign quad_next  = angle_bias[TURN_W-1 -: 2];
    assign resid      = angle - {quad_next, {(TURN_W-2){1'b0}}};

    assign xs = x_reg >>> iter_reg;
    assign ys = y_reg >>> iter_reg;
    assign at = atan_turn(iter_reg);

    always_comb
    begin
        if (!z_reg[CORDIC_W-1])
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
    end

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                s_pre = y_reg;
                c_pre = x_reg;
            end
            2'd1:
            begin
                s_pre = x_reg;
                c_pre = -y_reg;
            end
            2'd2:
            begin
                s_pre = -y_reg;
                c_pre = -x_reg;
            end
            default:
            begin
                s_pre = -x_reg;
                c_pre = y_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            iter_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (phase_reg == PH_MAP);
            case (phase_reg)
                PH_IDLE:
                begin
                    iter_reg <= '0;
                    if (start)
                    begin
                        phase_reg <= PH_ITER;
                    end
                end
                PH_ITER:
                begin
                    if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
                    begin
                        iter_reg  <= '0;
                        phase_reg <= PH_MAP;
                    end
                    else
                    begin
                        iter_reg <= iter_reg + 1'b1;
                    end
                end
                PH_MAP:
                begin
                    phase_reg <= PH_IDLE;
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    quad_reg <= quad_next;
                    x_reg    <= CORDIC_X0;
                    y_reg    <= '0;
                    z_reg    <= CORDIC_W'($signed(resid));
                end
            end
            PH_ITER:
            begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= z_next;
            end
            PH_MAP:
            begin
                sine_reg   <= to_q(s_pre);
                cosine_reg <= to_q(c_pre);
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    assign done   = done_reg;
    assign sine   = sine_reg;
    assign cosine = cosine_reg;

endmodule

@@ sv/trps_vel_mul.sv @@
// Digit-serial speed scaling of sine and cosine into velocity
`timescale 1ns / 1ps
module trps_vel_mul #(
    parameter int SINE_FRAC_BITS = 15
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [trps_pkg::SPEED_W-1:0]      speed,
    input  logic signed [SINE_FRAC_BITS:0]    sine,
    input  logic signed [SINE_FRAC_BITS:0]    cosine,
    output logic                              done,
    output logic signed [trps_pkg::VEL_W-1:0] vel_x,
    output logic signed [trps_pkg::VEL_W-1:0] vel_y
);
    import trps_pkg::*;

    localparam int SQ_W   = SINE_FRAC_BITS + 1;
    localparam int ACC_W  = SPEED_W + SQ_W + 1;
    localparam int PART_W = SQ_W + VMUL_DIGIT + 1;
    localparam int STEPS  = SPEED_W / VMUL_DIGIT;
    localparam int CNT_W  = $clog2(STEPS);
    localparam logic signed [ACC_W-1:0] V_ROUND = ACC_W'(64'sd1 <<< (SINE_FRAC_BITS - 1));

    logic                    run_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [SPEED_W-1:0]      speed_sh_reg;
    logic signed [SQ_W-1:0]  sin_reg;
    logic signed [SQ_W-1:0]  cos_reg;
    logic signed [ACC_W-1:0] acc_x_reg;
    logic signed [ACC_W-1:0] acc_y_reg;

    logic [VMUL_DIGIT-1:0]   dig;
    logic signed [PART_W-1:0] px;
    logic signed [PART_W-1:0] py;
    logic signed [ACC_W-1:0] acc_x_next;
    logic signed [ACC_W-1:0] acc_y_next;
    logic signed [ACC_W-1:0] rx;
    logic signed [ACC_W-1:0] ry;
    logic                    last;

    assign dig        = speed_sh_reg[SPEED_W-1 -: VMUL_DIGIT];
    assign px         = sin_reg * $signed({1'b0, dig});
    assign py         = cos_reg * $signed({1'b0, dig});
    assign acc_x_next = (acc_x_reg <<< VMUL_DIGIT) + ACC_W'(px);
    assign acc_y_next = (acc_y_reg <<< VMUL_DIGIT) + ACC_W'(py);
    assign last       = (cnt_reg == CNT_W'(STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && last;
            if (!run_reg)
            begin
                cnt_reg <= '0;
                run_reg <= start;
            end
            else if (last)
            begin
                cnt_reg <= '0;
                run_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!run_reg)
        begin
            if (start)
            begin
                speed_sh_reg <= speed;
                sin_reg      <= sine;
                cos_reg      <= cosine;
                acc_x_reg    <= '0;
                acc_y_reg    <= '0;
            end
        end
        else
        begin
            speed_sh_reg <= {speed_sh_reg[SPEED_W-VMUL_DIGIT-1:0], {VMUL_DIGIT{1'b0}}};
            acc_x_reg    <= acc_x_next;
            acc_y_reg    <= acc_y_next;
        end
    end

    assign rx    = (acc_x_reg + V_ROUND) >>> SINE_FRAC_BITS;
    assign ry    = (acc_y_reg + V_ROUND) >>> SINE_FRAC_BITS;
    assign vel_x = rx[VEL_W-1:0];
    assign vel_y = ry[VEL_W-1:0];
    assign done  = done_reg;

endmodule

@@ sv/turn_rate_limited_pursuit_steering.sv @@
// Turn-rate-limited pure-pursuit steering, top level
//
// One tick item in, one result item out. An inactive tick goes from acceptance
// through the first gate state to the output register; one stopped by the expiry,
// delay, period, track, range or view gates passes the second gate state too. A
// steered tick goes through the gates, the turn limit unit (4-bit multiply
// digits, then 3-bit restoring division by 1000), the clamp and heading add,
// the CORDIC unit (24 rotations plus quadrant fold and rounding), the 4-bit
// speed digits and the output register. One tick is in work at a time; a new
// tick is taken while the previous result still waits on result_stall.
`timescale 1ns / 1ps
`include "turn_rate_limited_pursuit_steering_assert.svh"
module turn_rate_limited_pursuit_steering #(
    parameter int ANGLE_BITS     = 16,
    parameter int SINE_FRAC_BITS = 15
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [trps_pkg::TIME_W-1:0]       now_ms,
    input  logic [trps_pkg::STEP_W-1:0]       step_ms,
    input  logic [ANGLE_BITS-1:0]             heading_in,
    input  logic                              track_present,
    input  logic [trps_pkg::IDENT_W-1:0]      track_ident,
    input  logic [trps_pkg::RANGE_W-1:0]      track_range,
    input  logic signed [ANGLE_BITS-1:0]      track_bearing,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [trps_pkg::STATUS_W-1:0]     status,
    output logic signed [trps_pkg::VEL_W-1:0] vel_x,
    output logic signed [trps_pkg::VEL_W-1:0] vel_y,
    output logic [ANGLE_BITS-1:0]             heading_out,
    output logic                              still_active,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [trps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trps_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import trps_pkg::*;

    localparam int VIEW_W = (ANGLE_BITS + 1 > FOV_W) ? ANGLE_BITS + 1 : FOV_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_GATE1   = 4'd1;
    localparam logic [3:0] S_GATE2   = 4'd2;
    localparam logic [3:0] S_LIMIT   = 4'd3;
    localparam logic [3:0] S_CLAMP   = 4'd4;
    localparam logic [3:0] S_TRIG_GO = 4'd5;
    localparam logic [3:0] S_TRIG    = 4'd6;
    localparam logic [3:0] S_VEL     = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    trps_cfg_t cfg;

    logic [3:0]               state_reg;
    logic                     active_reg;
    logic                     launched_reg;
    logic [TIME_W-1:0]        launch_stamp_reg;
    logic [TIME_W-1:0]        last_steer_reg;
    logic signed [VEL_W-1:0]  held_vel_x_reg;
    logic signed [VEL_W-1:0]  held_vel_y_reg;
    logic                     out_valid_reg;

    logic [TIME_W-1:0]        now_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [ANGLE_BITS-1:0]    hdg_reg;
    logic                     present_reg;
    logic [IDENT_W-1:0]       ident_reg;
    logic [RANGE_W-1:0]       range_reg;
    logic signed [ANGLE_BITS-1:0] bearing_reg;
    logic [TIME_W-1:0]        elapsed_reg;
    logic [TIME_W-1:0]        since_reg;
    logic [STATUS_W-1:0]      status_reg;

    logic [STATUS_W-1:0]      out_status_reg;
    logic signed [VEL_W-1:0]  out_vel_x_reg;
    logic signed [VEL_W-1:0]  out_vel_y_reg;
    logic [ANGLE_BITS-1:0]    out_heading_reg;
    logic                     out_active_reg;

    logic                     expired;
    logic                     delayed;
    logic                     waiting;
    logic                     no_track;
    logic                     out_range;
    logic                     out_view;
    logic [ANGLE_BITS-1:0]    mag;
    logic [VIEW_W-1:0]        twice_mag;
    logic [STATUS_W-1:0]      status_gate;
    logic                     out_free;

    logic                     lim_start;
    logic                     lim_done;
    logic [PROD_W-1:0]        lim;
    logic                     lim_big;
    logic signed [ANGLE_BITS:0] lim_pos;
    logic signed [ANGLE_BITS:0] lim_neg;
    logic signed [ANGLE_BITS:0] b_ext;
    logic signed [ANGLE_BITS:0] turn;
    logic [ANGLE_BITS-1:0]    hdg_next;

    logic                     cordic_start;
    logic                     cordic_done;
    logic signed [SINE_FRAC_BITS:0] sine;
    logic signed [SINE_FRAC_BITS:0] cosine;
    logic                     vel_start;
    logic                     vel_done;
    logic signed [VEL_W-1:0]  vel_x_new;
    logic signed [VEL_W-1:0]  vel_y_new;

    trps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    trps_limit u_limit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (lim_start),
        .turn_rate (cfg.turn_rate),
        .step_ms   (step_reg),
        .done      (lim_done),
        .lim       (lim)
    );

    trps_cordic #(
        .SINE_FRAC_BITS (SINE_FRAC_BITS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cordic_start),
        .angle  ({hdg_reg, {(TURN_W-ANGLE_BITS){1'b0}}}),
        .done   (cordic_done),
        .sine   (sine),
        .cosine (cosine)
    );

    trps_vel_mul #(
        .SINE_FRAC_BITS (SINE_FRAC_BITS)
    ) u_vel (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (vel_start),
        .speed  (cfg.cruise_speed),
        .sine   (sine),
        .cosine (cosine),
        .done   (vel_done),
        .vel_x  (vel_x_new),
        .vel_y  (vel_y_new)
    );

    // gate checks on registered time differences and the registered track fields
    assign expired   = (cfg.flight_limit_ms != '0) && (elapsed_reg > cfg.flight_limit_ms);
    assign delayed   = (elapsed_reg < cfg.start_delay_ms);
    assign waiting   = (cfg.update_period_ms != '0) && (since_reg < cfg.update_period_ms);
    assign no_track  = !(present_reg && (ident_reg == cfg.wanted_track));
    assign out_range = (cfg.lock_range != '0) && (range_reg > cfg.lock_range);
    assign mag       = bearing_reg[ANGLE_BITS-1] ? (~bearing_reg + 1'b1) : bearing_reg;
    assign twice_mag = VIEW_W'({mag, 1'b0});
    assign out_view  = (cfg.field_of_view != '0) && (twice_mag > VIEW_W'(cfg.field_of_view));

    always_comb
    begin
        if (expired)
        begin
            status_gate = ST_EXPIRED;
        end
        else if (delayed)
        begin
            status_gate = ST_DELAY;
        end
        else if (waiting)
        begin
            status_gate = ST_PERIOD;
        end
        else if (no_track)
        begin
            status_gate = ST_NO_TRACK;
        end
        else if (out_range)
        begin
            status_gate = ST_RANGE;
        end
        else if (out_view)
        begin
            status_gate = ST_VIEW;
        end
        else
        begin
            status_gate = ST_STEERED;
        end
    end

    // clamp bearing to the turn limit; a limit of half a turn or more never binds
    assign lim_big  = |lim[PROD_W-1:ANGLE_BITS-1];
    assign lim_pos  = $signed({2'b00, lim[ANGLE_BITS-2:0]});
    assign lim_neg  = -lim_pos;
    assign b_ext    = (ANGLE_BITS+1)'(bearing_reg);

    always_comb
    begin
        if (lim_big)
        begin
            turn = b_ext;
        end
        else if (b_ext > lim_pos)
        begin
            turn = lim_pos;
        end
        else if (b_ext < lim_neg)
        begin
            turn = lim_neg;
        end
        else
        begin
            turn = b_ext;
        end
    end

    assign hdg_next     = hdg_reg + turn[ANGLE_BITS-1:0];
    assign lim_start    = (state_reg == S_GATE2) && (status_gate == ST_STEERED);
    assign cordic_start = (state_reg == S_TRIG_GO);
    assign vel_start    = (state_reg == S_TRIG) && cordic_done;
    assign out_free     = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            active_reg       <= 1'b1;
            launched_reg     <= 1'b0;
            launch_stamp_reg <= '0;
            last_steer_reg   <= '0;
            held_vel_x_reg   <= '0;
            held_vel_y_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        state_reg <= S_GATE1;
                    end
                end
                S_GATE1:
                begin
                    if (!active_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (!launched_reg)
                        begin
                            launched_reg     <= 1'b1;
                            launch_stamp_reg <= now_reg;
                        end
                        state_reg <= S_GATE2;
                    end
                end
                S_GATE2:
                begin
                    if (expired)
                    begin
                        active_reg <= 1'b0;
                        state_reg  <= S_DONE;
                    end
                    else if (delayed || waiting)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        last_steer_reg <= now_reg;
                        state_reg <= (status_gate == ST_STEERED) ? S_LIMIT : S_DONE;
                    end
                end
                S_LIMIT:
                begin
                    if (lim_done)
                    begin
                        state_reg <= S_CLAMP;
                    end
                end
                S_CLAMP:
                begin
                    state_reg <= S_TRIG_GO;
                end
                S_TRIG_GO:
                begin
                    state_reg <= S_TRIG;
                end
                S_TRIG:
                begin
                    if (cordic_done)
                    begin
                        state_reg <= S_VEL;
                    end
                end
                S_VEL:
                begin
                    if (vel_done)
                    begin
                        held_vel_x_reg <= vel_x_new;
                        held_vel_y_reg <= vel_y_new;
                        state_reg      <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    now_reg     <= now_ms;
                    step_reg    <= step_ms;
                    hdg_reg     <= heading_in;
                    present_reg <= track_present;
                    ident_reg   <= track_ident;
                    range_reg   <= track_range;
                    bearing_reg <= track_bearing;
                end
            end
            S_GATE1:
            begin
                elapsed_reg <= launched_reg ? (now_reg - launch_stamp_reg) : '0;
                since_reg   <= now_reg - last_steer_reg;
                status_reg  <= ST_INACTIVE;
            end
            S_GATE2:
            begin
                status_reg <= status_gate;
            end
            S_CLAMP:
            begin
                hdg_reg <= hdg_next;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_status_reg  <= status_reg;
                    out_vel_x_reg   <= held_vel_x_reg;
                    out_vel_y_reg   <= held_vel_y_reg;
                    out_heading_reg <= hdg_reg;
                    out_active_reg  <= active_reg;
                end
            end
            default:
            begin
                status_reg <= status_reg;
            end
        endcase
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign vel_x        = out_vel_x_reg;
    assign vel_y        = out_vel_y_reg;
    assign heading_out  = out_heading_reg;
    assign still_active = out_active_reg;

    `TRPS_ASSERT_NEXT(a_inactive_sticks, !active_reg, !active_reg, "active flag came back")
    `TRPS_ASSERT_NOW(a_steer_active, result_valid && (status == ST_STEERED), still_active,
        "steered result from inactive block")
    `TRPS_ASSERT_NOW(a_expire_clears, result_valid && (status == ST_EXPIRED), !still_active,
        "expired result still active")
    `TRPS_ASSERT_NEXT(a_done_waits, (state_reg == S_DONE) && out_valid_reg && result_stall,
        state_reg == S_DONE, "result overwritten while stalled")

endmodule

@@ test/turn_rate_limited_pursuit_steering_tb.sv @@
// Self-checking bench for the pursuit steering block: predicted commands against the outputs
`timescale 1ns / 1ps

import trps_pkg::*;

localparam int HDG_W     = 16;
localparam int SINE_FRAC = 15;

typedef struct {
    logic [TIME_W-1:0]         now;
    logic [STEP_W-1:0]         step;
    logic [HDG_W-1:0]          heading;
    logic                      present;
    logic [IDENT_W-1:0]        ident;
    logic [RANGE_W-1:0]        range;
    logic signed [HDG_W-1:0]   bearing;
} tick_t;

typedef struct {
    logic [STATUS_W-1:0]       status;
    logic signed [VEL_W-1:0]   vel_x;
    logic signed [VEL_W-1:0]   vel_y;
    logic [HDG_W-1:0]          heading;
    logic                      alive;
} command_t;

class steer_checker;
    trps_cfg_t                 regs = '0;
    bit                        alive = 1'b1;
    bit                        launched;
    bit [TIME_W-1:0]           launch_at;
    bit [TIME_W-1:0]           last_steer_at;
    logic signed [VEL_W-1:0]   held_x = '0;
    logic signed [VEL_W-1:0]   held_y = '0;
    command_t                  pending_commands[$];
    int                        mismatches;
    longint                    arc_step [CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_FLIGHT_LIMIT:  regs.flight_limit_ms  = val;
            CFG_START_DELAY:   regs.start_delay_ms   = val;
            CFG_UPDATE_PERIOD: regs.update_period_ms = val;
            CFG_LOCK_RANGE:    regs.lock_range       = val[RANGE_W-1:0];
            CFG_FIELD_OF_VIEW: regs.field_of_view    = val[FOV_W-1:0];
            CFG_TURN_RATE:     regs.turn_rate        = val[RATE_W-1:0];
            CFG_CRUISE_SPEED:  regs.cruise_speed     = val[SPEED_W-1:0];
            CFG_WANTED_TRACK:  regs.wanted_track     = val[IDENT_W-1:0];
            default: ;
        endcase
    endfunction

    function longint to_q15(longint v);
        longint r;
        r = (v + (64'sd1 <<< (CORDIC_FRAC - SINE_FRAC - 1))) >>> (CORDIC_FRAC - SINE_FRAC);
        if (r > (64'sd1 <<< SINE_FRAC) - 1)
            r = (64'sd1 <<< SINE_FRAC) - 1;
        if (r < -(64'sd1 <<< SINE_FRAC))
            r = -(64'sd1 <<< SINE_FRAC);
        return r;
    endfunction

    function logic signed [VEL_W-1:0] scale_by_speed(longint q);
        longint p;
        p = longint'(regs.cruise_speed) * q;
        return VEL_W'((p + (64'sd1 <<< (SINE_FRAC - 1))) >>> SINE_FRAC);
    endfunction

    // z is a full turn per 2^32
    function void sine_cosine(bit [TURN_W-1:0] z, output longint s, output longint c);
        bit [TURN_W-1:0] shifted;
        bit [1:0]        quad;
        longint          r, x, y, nx, ny;
        int              i;
        shifted = z + 32'h2000_0000;
        quad = shifted[31:30];
        shifted = z - {quad, 30'd0};
        r = longint'($signed(shifted));
        x = CORDIC_X0;
        y = 0;
        for (i = 0; i < CORDIC_STEPS; i++)
        begin
            if (r >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                r -= arc_step[i];
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                r += arc_step[i];
            end
            x = nx;
            y = ny;
        end
        case (quad)
            2'd0:    begin s = y;  c = x;  end
            2'd1:    begin s = x;  c = -y; end
            2'd2:    begin s = -y; c = -x; end
            default: begin s = -x; c = y;  end
        endcase
        s = to_q15(s);
        c = to_q15(c);
    endfunction

    function void note_tick(tick_t t);
        command_t        want;
        bit [TIME_W-1:0] elapsed;
        bit [TIME_W-1:0] since_steer;
        longint          bearing, mag, limit, turn, s, c;
        want.heading = t.heading;
        if (!alive)
            want.status = ST_INACTIVE;
        else
        begin
            if (!launched)
            begin
                launched = 1'b1;
                launch_at = t.now;
            end
            elapsed = t.now - launch_at;
            since_steer = t.now - last_steer_at;
            bearing = longint'(t.bearing);
            mag = (bearing < 0) ? -bearing : bearing;
            if (regs.flight_limit_ms != 0 && elapsed > regs.flight_limit_ms)
            begin
                alive = 1'b0;
                want.status = ST_EXPIRED;
            end
            else if (elapsed < regs.start_delay_ms)
                want.status = ST_DELAY;
            else if (regs.update_period_ms != 0 && since_steer < regs.update_period_ms)
                want.status = ST_PERIOD;
            else
            begin
                last_steer_at = t.now;
                if (!t.present || t.ident != regs.wanted_track)
                    want.status = ST_NO_TRACK;
                else if (regs.lock_range != 0 && t.range > regs.lock_range)
                    want.status = ST_RANGE;
                else if (regs.field_of_view != 0 && 2 * mag > longint'(regs.field_of_view))
                    want.status = ST_VIEW;
                else
                begin
                    limit = longint'(regs.turn_rate) * longint'(t.step) / 1000;
                    turn = bearing;
                    if (turn > limit)
                        turn = limit;
                    if (turn < -limit)
                        turn = -limit;
                    want.heading = HDG_W'(longint'(t.heading) + turn);
                    sine_cosine({want.heading, 16'd0}, s, c);
                    held_x = scale_by_speed(s);
                    held_y = scale_by_speed(c);
                    want.status = ST_STEERED;
                end
            end
        end
        want.vel_x = held_x;
        want.vel_y = held_y;
        want.alive = alive;
        pending_commands.push_back(want);
    endfunction

    function void check_command(command_t got);
        command_t want;
        if (pending_commands.size() == 0)
        begin
            if (mismatches < 10)
                $display("%0t: unexpected item, status %0d heading %0d",
                         $time, got.status, got.heading);
            mismatches++;
            return;
        end
        want = pending_commands.pop_front();
        if (got.status !== want.status || got.vel_x !== want.vel_x ||
            got.vel_y !== want.vel_y || got.heading !== want.heading ||
            got.alive !== want.alive)
        begin
            if (mismatches < 10)
                $display({"%0t: mismatch, expected status %0d vel %0d,%0d hdg %0d act %0b,",
                          " got status %0d vel %0d,%0d hdg %0d act %0b"},
                         $time, want.status, want.vel_x, want.vel_y, want.heading,
                         want.alive, got.status, got.vel_x, got.vel_y, got.heading,
                         got.alive);
            mismatches++;
        end
    endfunction
endclass

module turn_rate_limited_pursuit_steering_tb;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 400;

    logic                     clk;
    logic                     rst_n;
    logic                     item_valid;
    logic                     item_stall;
    logic [TIME_W-1:0]        now_ms;
    logic [STEP_W-1:0]        step_ms;
    logic [HDG_W-1:0]         heading_in;
    logic                     track_present;
    logic [IDENT_W-1:0]       track_ident;
    logic [RANGE_W-1:0]       track_range;
    logic signed [HDG_W-1:0]  track_bearing;
    logic                     result_valid;
    logic                     result_stall;
    logic [STATUS_W-1:0]      status;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_y;
    logic [HDG_W-1:0]         heading_out;
    logic                     still_active;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    steer_checker   cmd_check = new();
    bit             calm;
    bit             hold_active;
    event           hold_start;
    logic [31:0]    clock_ms;
    command_t       seen;

    turn_rate_limited_pursuit_steering dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        hold_active = 1'b0;
        forever
        begin
            @(hold_start);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active = 1'b0;
        end
    end

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            result_stall <= hold_active || (!calm && $urandom_range(0, 99) < 7);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            seen.status  = status;
            seen.vel_x   = vel_x;
            seen.vel_y   = vel_y;
            seen.heading = heading_out;
            seen.alive   = still_active;
            cmd_check.check_command(seen);
        end
    end

    // ends the run when no channel has moved an item for too long
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_tick(tick_t t);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 7)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid    <= 1'b1;
        now_ms        <= t.now;
        step_ms       <= t.step;
        heading_in    <= t.heading;
        track_present <= t.present;
        track_ident   <= t.ident;
        track_range   <= t.range;
        track_bearing <= t.bearing;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        cmd_check.note_tick(t);
    endtask

    task automatic tick_in(logic [31:0] now, logic [15:0] step, logic [15:0] hdg, logic pres,
                           logic [15:0] id, logic [23:0] rng, logic signed [15:0] brg);
        tick_t t;
        t.now     = now;
        t.step    = step;
        t.heading = hdg;
        t.present = pres;
        t.ident   = id;
        t.range   = rng;
        t.bearing = brg;
        send_tick(t);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (cmd_check.pending_commands.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cmd_check.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] limit, delay, period,
                             input logic [23:0] lock, input logic [15:0] fov,
                             input logic [19:0] rate, input logic [15:0] speed,
                             input logic [15:0] wanted);
        wait_drained();
        write_reg(CFG_FLIGHT_LIMIT, limit);
        write_reg(CFG_START_DELAY, delay);
        write_reg(CFG_UPDATE_PERIOD, period);
        write_reg(CFG_LOCK_RANGE, lock);
        write_reg(CFG_FIELD_OF_VIEW, fov);
        write_reg(CFG_TURN_RATE, rate);
        write_reg(CFG_CRUISE_SPEED, speed);
        write_reg(CFG_WANTED_TRACK, wanted);
    endtask

    // mostly well-formed tracks around the current gates, some noise
    function automatic tick_t random_tick(bit free_time);
        tick_t t;
        int    pick;
        int    mag;
        if (free_time)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, 16);
        t.now = clock_ms;
        t.step = ($urandom_range(0, 99) < 10) ? 16'($urandom) : 16'($urandom_range(0, 300));
        t.heading = 16'($urandom);
        t.present = ($urandom_range(0, 99) < 88);
        t.ident = ($urandom_range(0, 99) < 80) ? cmd_check.regs.wanted_track : 16'($urandom);
        pick = $urandom_range(0, 99);
        if (cmd_check.regs.lock_range != 0 && pick < 70)
            t.range = 24'($urandom_range(0, cmd_check.regs.lock_range));
        else if (pick < 80)
            t.range = cmd_check.regs.lock_range;
        else
            t.range = 24'($urandom);
        if (cmd_check.regs.field_of_view != 0 && $urandom_range(0, 99) < 60)
        begin
            mag = $urandom_range(0, cmd_check.regs.field_of_view / 2 + 1);
            if ($urandom_range(0, 1))
                mag = -mag;
            t.bearing = 16'(mag);
        end
        else
            t.bearing = 16'($urandom);
        return t;
    endfunction

    task automatic run_phase(int count, bit free_time);
        repeat (count) send_tick(random_tick(free_time));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        now_ms        = '0;
        step_ms       = '0;
        heading_in    = '0;
        track_present = 1'b0;
        track_ident   = '0;
        track_range   = '0;
        track_bearing = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_FLIGHT_LIMIT;
        cfg_data      = '0;
        calm          = 1'b0;
        clock_ms      = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: launch, first period from zero, the period, track, range and view gates and the wrap cases
        configure(0, 0, 50, 5000, 16'h8000, 1000, 16'hFFFF, 16'h1234);
        tick_in(10, 5, 16'h0100, 1'b1, 16'h1234, 0, 0);
        tick_in(60, 5, 16'h0100, 1'b0, 16'h1234, 0, 0);
        tick_in(80, 5, 16'h0100, 1'b1, 16'h1234, 0, 0);
        tick_in(110, 5, 16'h0100, 1'b1, 16'h1235, 0, 0);
        tick_in(160, 5, 16'h0000, 1'b1, 16'h1234, 5001, 0);
        tick_in(210, 10, 16'h0000, 1'b1, 16'h1234, 5000, 16'sh4001);
        tick_in(260, 10, 16'h0000, 1'b1, 16'h1234, 5000, 16'sh4000);
        tick_in(310, 10, 16'h0000, 1'b1, 16'h1234, 0, 16'sh8000);
        tick_in(360, 16'hFFFF, 16'hFFFF, 1'b1, 16'h1234, 0, 16'sd100);
        tick_in(410, 0, 16'h0000, 1'b1, 16'h1234, 0, -16'sd5);
        tick_in(460, 100, 16'h0005, 1'b1, 16'h1234, 0, -16'sd20);
        tick_in(510, 1, 16'h0000, 1'b1, 16'h1234, 0, 16'sh7FFF);
        tick_in(560, 1, 16'h4000, 1'b1, 16'h1234, 0, 0);
        tick_in(610, 1, 16'h8000, 1'b1, 16'h1234, 0, 0);
        tick_in(660, 1, 16'hC000, 1'b1, 16'h1234, 0, 0);
        tick_in(710, 1, 16'h2000, 1'b1, 16'h1234, 0, 16'sd3000);
        tick_in(760, 1, 16'h0000, 1'b1, 16'h1234, 24'hFFFFFF, 0);
        tick_in(32'hFFFF_FFFF, 16'h8000, 16'h1234, 1'b1, 16'h1234, 0, -16'sd1);
        tick_in(0, 1, 16'h0000, 1'b1, 16'h1234, 0, 0);
        tick_in(100, 999, 16'hABCD, 1'b1, 16'h1234, 0, -16'sd1000);
        configure(0, 0, 0, 0, 0, 1000, 16'hFFFF, 16'h1234);
        tick_in(200, 16'hFFFF, 16'h0123, 1'b1, 16'h1234, 24'hFFFFFF, 16'sh8000);
        tick_in(210, 16'hFFFF, 16'h0123, 1'b1, 16'h1234, 24'hABCDEF, 16'sh7FFF);

        // expiry, delay, period, range and view gates open, free-running time, no idling on either side
        configure(0, 0, 0, 0, 0, 20'($urandom), 16'hFFFF, 0);
        calm <= 1'b1;
        run_phase(70, 1'b1);
        calm <= 1'b0;

        // widest expiry, lock range and view gates; receiver holds off while ticks keep coming
        configure(32'hFFFF_FFFF, 0, 25, 24'hFFFFFF, 16'hFFFF, 20'hFFFFF, 16'($urandom),
                  16'hFFFF);
        -> hold_start;
        run_phase(100, 1'b0);

        // start delay running out part way, sender pauses until all commands are back
        clock_ms = cmd_check.launch_at + $urandom_range(1000, 1000000);
        configure(0, clock_ms - cmd_check.launch_at + 300, $urandom_range(0, 40),
                  24'($urandom), 16'($urandom), 20'($urandom), 16'($urandom),
                  16'($urandom));
        run_phase(50, 1'b0);
        wait_drained();
        run_phase(50, 1'b0);

        configure(0, 32'hFFFF_FFFF, 0, 24'($urandom), 16'($urandom), 0, 0, 0);
        run_phase(20, 1'b1);
        configure(0, 0, 32'hFFFF_FFFF, 0, 0, 20'hFFFFF, 0, 16'($urandom));
        run_phase(20, 1'b1);

        configure(0, 0, $urandom_range(0, 30), 24'($urandom_range(0, 4095)), 16'($urandom),
                  0, 16'($urandom), 16'($urandom));
        run_phase(50, 1'b0);

        // flight time runs out part way; the block then stays inactive
        clock_ms = cmd_check.launch_at + $urandom_range(1000, 100000);
        configure(clock_ms - cmd_check.launch_at + 400, 0, $urandom_range(0, 20),
                  24'($urandom), 16'($urandom), 20'($urandom), 16'($urandom),
                  16'($urandom));
        run_phase(100, 1'b0);

        wait_drained();
        repeat (64) @(posedge clk);
        if (cmd_check.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+sv
sv/trps_pkg.sv
sv/trps_cfg_regs.sv
sv/trps_limit.sv
sv/trps_cordic.sv
sv/trps_vel_mul.sv
sv/turn_rate_limited_pursuit_steering.sv
test/turn_rate_limited_pursuit_steering_tb.sv
